@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int STAT_W  = 2;
	localparam int FILL_W  = 5;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 40;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_entry;
	} op_t;

endpackage

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One cell of the sorted row: holds an entry, compares it with an incoming
// priority and takes its own, the new or a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic            clk,
	input  spq_pkg::op_t    op,
	input  logic            occupied,
	input  logic            ge_prev,
	input  spq_pkg::entry_t entry_prev,
	input  spq_pkg::entry_t entry_next,
	output logic            ge,
	output spq_pkg::entry_t entry
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// set when the new entry lands here or ahead of us (ties stay ahead)
	assign ge    = !(occupied && (entry_q.prio <= op.new_entry.prio));
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (op.ins && ge && !ge_prev) begin
			entry_d = op.new_entry;
		end else if (op.ins && ge) begin
			entry_d = entry_prev;
		end else if (op.rem) begin
			entry_d = entry_next;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

@@ sv/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded min-first priority queue kept sorted in a row of shifting cells;
// equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                   | tuser | tlast
// s_*     | in  | req_type, item_value, priority_req          | -     | -
// m_*     | out | status, removed_value, fill_count           | -     | -
//
// one item per cycle while s_tready is high: every cell compares and shifts in the same cycle
// the result register sits between the sides; s_tready is low only while a
// result waits and m_tready is low
// reset clears the fill count and the result valid; cell contents stay
// undefined and are only read below the fill count
module stable_priority_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // req_type, item_value, priority_req
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [spq_pkg::OUT_W-1:0] m_tdata   // status, removed_value, fill_count
);

	localparam int D = spq_pkg::DEPTH;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_d;
	logic                      accept;
	logic                      req_type;
	logic                      full;
	logic                      empty;
	spq_pkg::op_t              op;
	spq_pkg::status_t          status_d;
	logic [spq_pkg::VALUE_W-1:0] removed_d;

	logic                      m_valid_q;
	spq_pkg::status_t          status_q;
	logic [spq_pkg::VALUE_W-1:0] removed_q;
	logic [spq_pkg::FILL_W-1:0]  fill_q;

	logic            ge    [D];
	logic            occ   [D];
	spq_pkg::entry_t entry [D];

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign req_type = s_tdata[0];
	assign full     = (count_q == spq_pkg::CNT_W'(D));
	assign empty    = (count_q == '0);

	assign op.new_entry.value = s_tdata[spq_pkg::VALUE_W:1];
	assign op.new_entry.prio  = s_tdata[spq_pkg::VALUE_W+spq_pkg::PRIO_W:spq_pkg::VALUE_W+1];
	assign op.ins = accept && (req_type == spq_pkg::REQ_INSERT) && !full;
	assign op.rem = accept && (req_type == spq_pkg::REQ_REMOVE) && !empty;

	always_comb begin
		count_d   = count_q;
		status_d  = spq_pkg::ST_OK;
		removed_d = '0;
		if (req_type == spq_pkg::REQ_INSERT) begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				count_d = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_d = spq_pkg::ST_UNDERFLOW;
			end else begin
				count_d   = count_q - 1'b1;
				removed_d = entry[0].value;
			end
		end
	end

	for (genvar i = 0; i < D; i++) begin : g_cell
		assign occ[i] = (spq_pkg::CNT_W'(i) < count_q);
		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (occ[i]),
			.ge_prev    ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
			.entry_prev (entry[(i == 0) ? 0 : i - 1]),
			.entry_next (entry[(i == D - 1) ? i : i + 1]),
			.ge         (ge[i]),
			.entry      (entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= removed_d;
			fill_q    <= spq_pkg::FILL_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, fill_q, removed_q, status_q};

endmodule

@@ sv/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the priority queue result stream.
// ----------------------------------------------------------------------------
module spq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [spq_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [spq_pkg::OUT_W-1:0] m_tdata
);

	logic [1:0]  st;
	logic [31:0] rv;
	logic [4:0]  fc;

	assign st = m_tdata[1:0];
	assign rv = m_tdata[33:2];
	assign fc = m_tdata[38:34];

	// every accepted item gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != spq_pkg::ST_OK) |-> (rv == '0))
		else $error("failed request carries a value");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == spq_pkg::ST_UNDERFLOW) |-> (fc == '0))
		else $error("underflow with entries stored");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st == spq_pkg::ST_FULL) |-> (fc == 5'(spq_pkg::DEPTH)))
		else $error("full flag without a full store");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
